@@ design/gpl_pkg.sv @@
package gpl_pkg;

   typedef enum logic [11:0] {
      PH_L_OPEN   = 12'b0000_0000_0001,
      PH_L_FIRST  = 12'b0000_0000_0010,
      PH_L_NAME   = 12'b0000_0000_0100,
      PH_ARROW1   = 12'b0000_0000_1000,
      PH_ARROW2   = 12'b0000_0001_0000,
      PH_IDLE     = 12'b0000_0010_0000,
      PH_EPS      = 12'b0000_0100_0000,
      PH_NT_FIRST = 12'b0000_1000_0000,
      PH_NT       = 12'b0001_0000_0000,
      PH_TERM     = 12'b0010_0000_0000,
      PH_AT_FIRST = 12'b0100_0000_0000,
      PH_AT       = 12'b1000_0000_0000
   } phase_type;

   localparam logic [1:0] EV_CHAR  = 2'd0;
   localparam logic [1:0] EV_TOKEN = 2'd1;
   localparam logic [1:0] EV_LINE  = 2'd2;

   localparam logic [2:0] K_LEFT = 3'd0;
   localparam logic [2:0] K_NT   = 3'd1;
   localparam logic [2:0] K_TERM = 3'd2;
   localparam logic [2:0] K_EPS  = 3'd3;
   localparam logic [2:0] K_ATTR = 3'd4;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_BAD_LEFT   = 3'd1;
   localparam logic [2:0] ST_NO_ARROW   = 3'd2;
   localparam logic [2:0] ST_UNEXPECTED = 3'd3;
   localparam logic [2:0] ST_EMPTY      = 3'd4;
   localparam logic [2:0] ST_ORPHAN     = 3'd5;

   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_SPACE  = 8'h20;

   localparam logic [2:0] EPS_LEN = 3'd5;
   localparam int unsigned MAX_RESULTS = 3;

   typedef struct packed {
      logic [7:0] char_in;
      logic       char_valid;
      logic       end_of_line;
   } item_type;

   typedef struct packed {
      logic [1:0] event_res;
      logic [7:0] char_out;
      logic [2:0] token_kind;
      logic [2:0] status;
   } result_type;

   typedef struct packed {
      result_type [MAX_RESULTS-1:0] res;
      logic [1:0]                   count;
   } bundle_type;

   function automatic logic is_space(logic [7:0] c);
      return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic is_name_char(logic [7:0] c);
      if (c < 8'd33 || c > 8'd126) begin
         return 1'b0;
      end
      return (c != CH_LT) && (c != CH_GT) && (c != CH_HASH) &&
             (c != CH_LBRACE) && (c != CH_RBRACE);
   endfunction

   function automatic logic [7:0] eps_char(logic [2:0] pos);
      logic [7:0] c;
      unique case (pos)
         3'd0:    c = CH_HASH;
         3'd1:    c = 8'h45;
         3'd2:    c = 8'h70;
         3'd3:    c = 8'h73;
         3'd4:    c = CH_HASH;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic result_type make_result(logic [1:0] ev, logic [7:0] ch,
                                              logic [2:0] kind, logic [2:0] st);
      result_type r;
      r.event_res  = ev;
      r.char_out   = ch;
      r.token_kind = kind;
      r.status     = st;
      return r;
   endfunction

endpackage

@@ design/gpl_if.sv @@
interface gpl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;
   logic       char_valid;
   logic       end_of_line;

   modport source (output valid, output char_in, output char_valid, output end_of_line,
                   input ready);
   modport sink (input valid, input char_in, input char_valid, input end_of_line,
                 output ready);
endinterface

interface gpl_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] event_res;
   logic [7:0] char_out;
   logic [2:0] token_kind;
   logic [2:0] status;
   logic       last_of_run;

   modport source (output valid, output event_res, output char_out, output token_kind,
                   output status, output last_of_run, input ready);
   modport sink (input valid, input event_res, input char_out, input token_kind,
                 input status, input last_of_run, output ready);
endinterface

@@ design/grammar_production_lexer_top.sv @@
// grammar production lexer
// req_chan carries one character of a production line per item, with
// char_valid (0 for a bare end marker) and end_of_line to close the line.
// rsp_chan returns the events for each item in order: name characters,
// finished tokens with their kind, and a line status at end of line;
// last_of_run marks the final result of an item. An item may cause zero
// to three results.
// an item is registered in the input register on accept; its results are
// loaded into the result register once it is free, which shows the first.
// throughput: one item per cycle while each item causes at most one result
// and the receiver takes each result; an item with several results
// occupies the result register until all of them leave, one per handshake.
// a stalled receiver holds the current result; the input register then
// holds one more item and req_chan.ready drops until the result register
// frees up.
// reset clears the lexer to the start of a line and empties both registers.
module grammar_production_lexer_top (
   input  logic      clock,
   input  logic      reset,
   gpl_req_if.sink   req_chan,
   gpl_rsp_if.source rsp_chan
);

   gpl_pkg::item_type   item_ff;
   logic                in_valid_ff;
   logic                free;
   logic                advance;
   gpl_pkg::bundle_type bundle;

   assign advance        = in_valid_ff && free;
   assign req_chan.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         item_ff.char_in     <= req_chan.char_in;
         item_ff.char_valid  <= req_chan.char_valid;
         item_ff.end_of_line <= req_chan.end_of_line;
      end
   end

   gpl_step u_step (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_ff),
      .bundle  (bundle)
   );

   gpl_out u_out (
      .clock    (clock),
      .reset    (reset),
      .load     (in_valid_ff),
      .bundle   (bundle),
      .free     (free),
      .rsp_chan (rsp_chan)
   );

endmodule

@@ design/gpl_step.sv @@
module gpl_step (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  gpl_pkg::item_type   item,
   output gpl_pkg::bundle_type bundle
);

   typedef struct packed {
      gpl_pkg::phase_type phase;
      logic               eps_start;
      logic               err;
   } start_type;

   gpl_pkg::phase_type phase_ff, phase_in;
   logic [2:0]         eps_pos_ff, eps_pos_in;
   logic [2:0]         error_ff, error_in;
   logic               have_sym_ff, have_sym_in;

   function automatic start_type start_token(logic [7:0] c);
      start_type s;
      s.phase     = gpl_pkg::PH_IDLE;
      s.eps_start = 1'b0;
      s.err       = 1'b0;
      if (gpl_pkg::is_space(c)) begin
         s.phase = gpl_pkg::PH_IDLE;
      end else if (c == gpl_pkg::CH_HASH) begin
         s.phase     = gpl_pkg::PH_EPS;
         s.eps_start = 1'b1;
      end else if (c == gpl_pkg::CH_LT) begin
         s.phase = gpl_pkg::PH_NT_FIRST;
      end else if (c == gpl_pkg::CH_LBRACE) begin
         s.phase = gpl_pkg::PH_AT_FIRST;
      end else if (gpl_pkg::is_name_char(c)) begin
         s.phase = gpl_pkg::PH_TERM;
      end else begin
         s.err = 1'b1;
      end
      return s;
   endfunction

   always_comb begin
      gpl_pkg::phase_type ph;
      logic [2:0]         ep;
      logic [2:0]         er;
      logic               hs;
      logic [1:0]         n;
      logic [7:0]         c;
      logic               nm;
      logic               sp;
      start_type          st;

      ph = phase_ff;
      ep = eps_pos_ff;
      er = error_ff;
      hs = have_sym_ff;
      n  = 2'd0;
      c  = item.char_in;
      nm = gpl_pkg::is_name_char(c);
      sp = gpl_pkg::is_space(c);
      st = start_token(c);
      bundle.res = '0;

      if (item.char_valid && (error_ff == gpl_pkg::ST_OK)) begin
         unique case (phase_ff)
            gpl_pkg::PH_L_OPEN: begin
               if (c == gpl_pkg::CH_LT) ph = gpl_pkg::PH_L_FIRST;
               else if (!sp) er = gpl_pkg::ST_BAD_LEFT;
            end
            gpl_pkg::PH_L_FIRST: begin
               if (nm) begin
                  bundle.res[n] = gpl_pkg::make_result(gpl_pkg::EV_CHAR, c,
                                                       gpl_pkg::K_LEFT, gpl_pkg::ST_OK);
                  n  = n + 2'd1;
                  ph = gpl_pkg::PH_L_NAME;
               end else if (!sp) begin
                  er = gpl_pkg::ST_BAD_LEFT;
               end
            end
            gpl_pkg::PH_L_NAME: begin
               if (nm) begin
                  bundle.res[n] = gpl_pkg::make_result(gpl_pkg::EV_CHAR, c,
                                                       gpl_pkg::K_LEFT, gpl_pkg::ST_OK);
                  n = n + 2'd1;
               end else if (c == gpl_pkg::CH_GT) begin
                  bundle.res[n] = gpl_pkg::make_result(gpl_pkg::EV_TOKEN, 8'h00,
                                                       gpl_pkg::K_LEFT, gpl_pkg::ST_OK);
                  n  = n + 2'd1;
                  ph = gpl_pkg::PH_ARROW1;
               end else begin
                  er = gpl_pkg::ST_BAD_LEFT;
               end
            end
            gpl_pkg::PH_ARROW1: begin
               if (c == gpl_pkg::CH_DASH) ph = gpl_pkg::PH_ARROW2;
               else if (!sp) er = gpl_pkg::ST_NO_ARROW;
            end
            gpl_pkg::PH_ARROW2: begin
               if (c == gpl_pkg::CH_GT) ph = gpl_pkg::PH_IDLE;
               else er = gpl_pkg::ST_NO_ARROW;
            end
            gpl_pkg::PH_IDLE: begin
               if (st.err) begin
                  er = gpl_pkg::ST_UNEXPECTED;
               end else begin
                  ph = st.phase;
                  if (st.eps_start) ep = 3'd1;
                  if (nm) begin
                     bundle.res[n] = gpl_pkg::make_result(gpl_pkg::EV_CHAR, c,
                                                          gpl_pkg::K_LEFT, gpl_pkg::ST_OK);
                     n = n + 2'd1;
                  end
               end
            end
            gpl_pkg::PH_EPS: begin
               if ((eps_pos_ff < gpl_pkg::EPS_LEN) && (c == gpl_pkg::eps_char(eps_pos_ff)))
               begin
                  if (eps_pos_ff + 3'd1 == gpl_pkg::EPS_LEN) begin
                     bundle.res[n] = gpl_pkg::make_result(gpl_pkg::EV_TOKEN, 8'h00,
                                                          gpl_pkg::K_EPS, gpl_pkg::ST_OK);
                     n  = n + 2'd1;
                     hs = 1'b1;
                     ep = 3'd0;
                     ph = gpl_pkg::PH_IDLE;
                  end else begin
                     ep = eps_pos_ff + 3'd1;
                  end
               end else begin
                  er = gpl_pkg::ST_UNEXPECTED;
               end
            end
            gpl_pkg::PH_NT_FIRST, gpl_pkg::PH_AT_FIRST: begin
               if (nm) begin
                  bundle.res[n] = gpl_pkg::make_result(gpl_pkg::EV_CHAR, c,
                                                       gpl_pkg::K_LEFT, gpl_pkg::ST_OK);
                  n  = n + 2'd1;
                  ph = (phase_ff == gpl_pkg::PH_NT_FIRST) ? gpl_pkg::PH_NT : gpl_pkg::PH_AT;
               end else if (!sp) begin
                  er = gpl_pkg::ST_UNEXPECTED;
               end
            end
            gpl_pkg::PH_NT: begin
               if (nm) begin
                  bundle.res[n] = gpl_pkg::make_result(gpl_pkg::EV_CHAR, c,
                                                       gpl_pkg::K_LEFT, gpl_pkg::ST_OK);
                  n = n + 2'd1;
               end else if (c == gpl_pkg::CH_GT) begin
                  bundle.res[n] = gpl_pkg::make_result(gpl_pkg::EV_TOKEN, 8'h00,
                                                       gpl_pkg::K_NT, gpl_pkg::ST_OK);
                  n  = n + 2'd1;
                  hs = 1'b1;
                  ph = gpl_pkg::PH_IDLE;
               end else begin
                  er = gpl_pkg::ST_UNEXPECTED;
               end
            end
            gpl_pkg::PH_AT: begin
               if (nm) begin
                  bundle.res[n] = gpl_pkg::make_result(gpl_pkg::EV_CHAR, c,
                                                       gpl_pkg::K_LEFT, gpl_pkg::ST_OK);
                  n = n + 2'd1;
               end else if (c == gpl_pkg::CH_RBRACE) begin
                  if (have_sym_ff) begin
                     bundle.res[n] = gpl_pkg::make_result(gpl_pkg::EV_TOKEN, 8'h00,
                                                          gpl_pkg::K_ATTR, gpl_pkg::ST_OK);
                     n  = n + 2'd1;
                     ph = gpl_pkg::PH_IDLE;
                  end else begin
                     er = gpl_pkg::ST_ORPHAN;
                  end
               end else begin
                  er = gpl_pkg::ST_UNEXPECTED;
               end
            end
            gpl_pkg::PH_TERM: begin
               if (nm) begin
                  bundle.res[n] = gpl_pkg::make_result(gpl_pkg::EV_CHAR, c,
                                                       gpl_pkg::K_LEFT, gpl_pkg::ST_OK);
                  n = n + 2'd1;
               end else begin
                  // terminal ends here, then the character starts a new token
                  bundle.res[n] = gpl_pkg::make_result(gpl_pkg::EV_TOKEN, 8'h00,
                                                       gpl_pkg::K_TERM, gpl_pkg::ST_OK);
                  n  = n + 2'd1;
                  hs = 1'b1;
                  if (st.err) begin
                     er = gpl_pkg::ST_UNEXPECTED;
                  end else begin
                     ph = st.phase;
                     if (st.eps_start) ep = 3'd1;
                  end
               end
            end
            default: er = gpl_pkg::ST_UNEXPECTED;
         endcase
      end

      if (item.end_of_line) begin
         if (er == gpl_pkg::ST_OK) begin
            unique case (ph)
               gpl_pkg::PH_L_OPEN, gpl_pkg::PH_L_FIRST, gpl_pkg::PH_L_NAME:
                  er = gpl_pkg::ST_BAD_LEFT;
               gpl_pkg::PH_ARROW1, gpl_pkg::PH_ARROW2:
                  er = gpl_pkg::ST_NO_ARROW;
               gpl_pkg::PH_TERM: begin
                  bundle.res[n] = gpl_pkg::make_result(gpl_pkg::EV_TOKEN, 8'h00,
                                                       gpl_pkg::K_TERM, gpl_pkg::ST_OK);
                  n  = n + 2'd1;
                  hs = 1'b1;
               end
               gpl_pkg::PH_IDLE: ;
               default:
                  er = gpl_pkg::ST_UNEXPECTED;
            endcase
            if ((er == gpl_pkg::ST_OK) && !hs) er = gpl_pkg::ST_EMPTY;
         end
         bundle.res[n] = gpl_pkg::make_result(gpl_pkg::EV_LINE, 8'h00, gpl_pkg::K_LEFT, er);
         n  = n + 2'd1;
         ph = gpl_pkg::PH_L_OPEN;
         ep = 3'd0;
         er = gpl_pkg::ST_OK;
         hs = 1'b0;
      end

      bundle.count = n;
      phase_in     = ph;
      eps_pos_in   = ep;
      error_in     = er;
      have_sym_in  = hs;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= gpl_pkg::PH_L_OPEN;
         eps_pos_ff  <= 3'd0;
         error_ff    <= gpl_pkg::ST_OK;
         have_sym_ff <= 1'b0;
      end else if (advance) begin
         phase_ff    <= phase_in;
         eps_pos_ff  <= eps_pos_in;
         error_ff    <= error_in;
         have_sym_ff <= have_sym_in;
      end
   end

   // line state holds between items
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(phase_ff) && $stable(error_ff) && $stable(have_sym_ff))
      else $error("lexer state changed without an item");

   // first error of a line sticks until the line closes
   a_sticky: assert property (@(posedge clock) disable iff (reset)
      (advance && (error_ff != gpl_pkg::ST_OK) && !item.end_of_line)
      |=> (error_ff == $past(error_ff)))
      else $error("error code overwritten inside a line");

   // closing a line returns to the start state
   a_close: assert property (@(posedge clock) disable iff (reset)
      (advance && item.end_of_line)
      |=> (phase_ff == gpl_pkg::PH_L_OPEN) && (error_ff == gpl_pkg::ST_OK) && !have_sym_ff)
      else $error("line close did not clear state");

endmodule

@@ design/gpl_out.sv @@
module gpl_out (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  gpl_pkg::bundle_type bundle,
   output logic                free,
   gpl_rsp_if.source           rsp_chan
);

   gpl_pkg::bundle_type bundle_ff;
   logic [1:0]          idx_ff, idx_in;
   logic                valid_ff, valid_in;
   logic                pop;
   logic                last;
   logic                take;
   gpl_pkg::result_type cur;

   assign last = (idx_ff == bundle_ff.count - 2'd1);
   assign pop  = valid_ff && rsp_chan.ready;
   assign free = !valid_ff || (pop && last);
   assign take = load && free && (bundle.count != 2'd0);

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (take) begin
         valid_in = 1'b1;
         idx_in   = 2'd0;
      end else if (pop) begin
         if (last) begin
            valid_in = 1'b0;
            idx_in   = 2'd0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         bundle_ff <= bundle;
      end
   end

   assign cur                  = bundle_ff.res[idx_ff];
   assign rsp_chan.valid       = valid_ff;
   assign rsp_chan.event_res   = cur.event_res;
   assign rsp_chan.char_out    = cur.char_out;
   assign rsp_chan.token_kind  = cur.token_kind;
   assign rsp_chan.status      = cur.status;
   assign rsp_chan.last_of_run = valid_ff && last;

   a_index: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (bundle_ff.count != 2'd0) && (idx_ff < bundle_ff.count))
      else $error("result index outside the held item");

   a_wait: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp_chan.ready) |=> valid_ff && $stable(idx_ff))
      else $error("result moved while stalled");

   a_load: assert property (@(posedge clock) disable iff (reset)
      take |=> valid_ff && (idx_ff == 2'd0))
      else $error("loaded item not presented from its first result");

endmodule
